[hw/rtl/imaad_pkg.sv]
`default_nettype none

package imaad_pkg;

    // Field widths for the step index, step size, sample and datapath sums.
    localparam int unsigned IndexW   = 7;
    localparam int unsigned StepW    = 15;
    localparam int unsigned SampleW  = 16;
    localparam int unsigned DiffW    = 17;
    localparam int unsigned SumW     = 18;

    localparam logic [IndexW-1:0] MaxIndex = 7'd88;

    localparam logic signed [SumW-1:0] SampleMax = 18'sd32767;
    localparam logic signed [SumW-1:0] SampleMin = -18'sd32768;

    typedef logic [IndexW-1:0]         t_index;
    typedef logic [StepW-1:0]          t_step;
    typedef logic signed [SampleW-1:0] t_sample;
    typedef logic signed [4:0]         t_adjust;

    // One decoded sample pair as the two lanes hand it to the output stage.
    typedef struct packed {
        logic    last;
        t_sample right;
        t_sample left;
    } t_pair;

    // Standard IMA ADPCM step size table.
    localparam t_step StepTable [0:88] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,
        15'd12,    15'd13,    15'd14,    15'd16,    15'd17,
        15'd19,    15'd21,    15'd23,    15'd25,    15'd28,
        15'd31,    15'd34,    15'd37,    15'd41,    15'd45,
        15'd50,    15'd55,    15'd60,    15'd66,    15'd73,
        15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
        15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
        15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
        15'd337,   15'd371,   15'd408,   15'd449,   15'd494,
        15'd544,   15'd598,   15'd658,   15'd724,   15'd796,
        15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,
        15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
        15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,
        15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
        15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,
        15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
        15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
        15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    // Step size for an index; an index past the top reads the last entry.
    function automatic t_step step_of(input t_index idx);
        t_step s;
        if (idx > MaxIndex) begin
            s = StepTable[MaxIndex];
        end else begin
            s = StepTable[idx];
        end
        return s;
    endfunction

    // Standard IMA index adjustment, keyed by the three magnitude bits.
    function automatic t_adjust adjust_of(input logic [2:0] mag);
        t_adjust a;
        unique case (mag)
            3'd4:    a = 5'sd2;
            3'd5:    a = 5'sd4;
            3'd6:    a = 5'sd6;
            3'd7:    a = 5'sd8;
            default: a = -5'sd1;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/imaad_lane.sv]
`default_nettype none

module imaad_lane (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic [3:0]        i_code,
    output imaad_pkg::t_sample     o_sample,
    output imaad_pkg::t_index      o_index
);
    import imaad_pkg::*;

    t_sample r_pred;
    t_index  r_index;
    t_step   r_step;

    t_sample n_pred;
    t_index  n_index;
    t_step   n_step;

    logic [DiffW-1:0]       diff;
    logic signed [SumW-1:0] sum;
    logic signed [8:0]      idx_sum;

    // Difference built from the shifted step sizes.
    always_comb begin
        diff = DiffW'(r_step >> 3);
        if (i_code[2]) begin
            diff = diff + DiffW'(r_step);
        end
        if (i_code[1]) begin
            diff = diff + DiffW'(r_step >> 1);
        end
        if (i_code[0]) begin
            diff = diff + DiffW'(r_step >> 2);
        end
    end

    // Predictor update with saturation to the 16-bit range.
    always_comb begin
        if (i_code[3]) begin
            sum = SumW'(r_pred) - $signed({1'b0, diff});
        end else begin
            sum = SumW'(r_pred) + $signed({1'b0, diff});
        end
        if (sum > SampleMax) begin
            n_pred = SampleW'(SampleMax);
        end else if (sum < SampleMin) begin
            n_pred = SampleW'(SampleMin);
        end else begin
            n_pred = sum[SampleW-1:0];
        end
    end

    // Index update clamped to the table; the next step size is looked up
    // ahead so the following code starts from a registered step.
    always_comb begin
        idx_sum = $signed({2'b00, r_index}) + 9'(adjust_of(i_code[2:0]));
        if (idx_sum < 9'sd0) begin
            n_index = '0;
        end else if (idx_sum > $signed({2'b00, MaxIndex})) begin
            n_index = MaxIndex;
        end else begin
            n_index = idx_sum[IndexW-1:0];
        end
        n_step = step_of(n_index);
    end

    // Channel state advances once per accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred  <= '0;
            r_index <= '0;
            r_step  <= StepTable[0];
        end else if (i_en) begin
            r_pred  <= n_pred;
            r_index <= n_index;
            r_step  <= n_step;
        end
    end

    assign o_sample = n_pred;
    assign o_index  = r_index;

endmodule

`default_nettype wire

[hw/rtl/imaad_merge.sv]
`default_nettype none

module imaad_merge (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire imaad_pkg::t_pair  i_pair,
    output logic                   o_ready,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [31:0]            o_m_tdata,
    output logic                   o_m_tlast
);
    import imaad_pkg::*;

    logic  r_out_valid;
    logic  r_skid_valid;
    t_pair r_out;
    t_pair r_skid;
    logic  out_take;

    assign out_take = r_out_valid & i_m_tready;

    // Control of the output register and the skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload moves without reset.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (i_valid) begin
            if (!r_out_valid || out_take) begin
                r_out <= i_pair;
            end else begin
                r_skid <= i_pair;
            end
        end
    end

    assign o_ready    = ~r_skid_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.right, r_out.left};
    assign o_m_tlast  = r_out.last;

endmodule

`default_nettype wire

[hw/rtl/stereo_ima_adpcm_decoder_core.sv]
`default_nettype none

// Channel   | Direction | Signals                          | Payload
// ----------+-----------+----------------------------------+---------------------------------
// s (in)    | slave     | tvalid tready tdata[7:0] tlast   | code_byte; tlast = block_end
// m (out)   | master    | tvalid tready tdata[31:0] tlast  | left, right; tlast = block_end_out
//
// One byte per cycle while the output is not stalled; each result is registered
// in the output or skid stage. The left and right lanes each close a loop through
// the predictor add and clamp, which sets that rate; the step size is registered.
// Reset (i_rst_n low, synchronous) clears both predictors and step indexes.
// An output register plus a skid stage keep input transfers going for one
// more byte while the output is stalled; tready drops only when both are full.

module stereo_ima_adpcm_decoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] code_byte
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [15:0] left_sample, [31:16] right_sample
    output logic             o_m_tlast
);
    import imaad_pkg::*;

    logic    in_fire;
    t_sample left_sample;
    t_sample right_sample;
    t_index  left_index;
    t_index  right_index;
    t_pair   pair;

    assign in_fire = i_s_tvalid & o_s_tready;

    // Left lane decodes the low nibble.
    imaad_lane u_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (in_fire),
        .i_code   (i_s_tdata[3:0]),
        .o_sample (left_sample),
        .o_index  (left_index)
    );

    // Right lane decodes the high nibble.
    imaad_lane u_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (in_fire),
        .i_code   (i_s_tdata[7:4]),
        .o_sample (right_sample),
        .o_index  (right_index)
    );

    always_comb begin
        pair.left  = left_sample;
        pair.right = right_sample;
        pair.last  = i_s_tlast;
    end

    // Output stage joins the two lanes into one transfer.
    imaad_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_fire),
        .i_pair     (pair),
        .o_ready    (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // Input back-pressure only while a result is waiting at the output.
    a_ready_low_needs_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with no result waiting");

    // A transfer into a stalled full output fills the skid stage.
    a_skid_fills : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready && in_fire) |=> !o_s_tready)
        else $error("skid stage did not take the byte");

    // Ready falls only when the output was held by the sink.
    a_ready_fall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_tready) |-> $past(o_m_tvalid && !i_m_tready))
        else $error("ready dropped without a stalled output");

    // Both step indexes stay inside the table.
    a_index_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (left_index <= MaxIndex) && (right_index <= MaxIndex))
        else $error("step index beyond table");

endmodule

`default_nettype wire
